/* src/md5_pkg.sv */
`timescale 1ns / 1ps
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [31:0] data_bytes;
        logic [2:0]  byte_count;
        logic        end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_round_ctl;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            unique case (i)
                6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
                6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
                6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
                default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        begin
            unique case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
                4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
                4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        begin
            unique case (i[5:4])
                2'd0: g = i[3:0];
                2'd1: g = 4'(5 * i[3:0] + 1);
                2'd2: g = 4'(3 * i[3:0] + 5);
                default: g = 4'(7 * i[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage

/* src/md5_stream_if.sv */
`timescale 1ns / 1ps
interface md5_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* src/md5_round.sv */
`timescale 1ns / 1ps
module md5_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  md5_pkg::t_round_ctl   i_ctl,
    input  logic [31:0]           i_chain [4],
    input  logic [31:0]           i_msg,
    output logic [5:0]            o_round,
    output logic [31:0]           o_sum [4]
);
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_round;
    logic [31:0] f, sum, rot;
    logic [4:0]  s;

    always_comb begin
        unique case (r_round[5:4])
            2'd0: f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1: f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        s   = md5_pkg::round_s(r_round);
        sum = r_a + f + md5_pkg::round_k(r_round) + i_msg;
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else if (i_ctl.start) begin
            r_round <= '0;
        end else if (i_ctl.busy) begin
            r_round <= r_round + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= i_chain[0];
            r_b <= i_chain[1];
            r_c <= i_chain[2];
            r_d <= i_chain[3];
        end else if (i_ctl.busy) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
    end

    assign o_round  = r_round;
    assign o_sum[0] = i_chain[0] + r_a;
    assign o_sum[1] = i_chain[1] + r_b;
    assign o_sum[2] = i_chain[2] + r_c;
    assign o_sum[3] = i_chain[3] + r_d;
endmodule

/* src/md5_stream_hash.sv */
`timescale 1ns / 1ps
// Streaming MD5. Each input beat carries up to four bytes; after the accept
// cycle the block stores them byte by byte, then takes a closing step before
// it accepts the next beat. A beat that completes a 64-byte block also runs
// the compression: one shared round unit does one round per cycle, and a
// fold step then adds the results into the chaining words. An end-of-message
// beat pads byte by byte (one or two blocks), then presents the four digest
// words A..D as output beats, one per cycle while the sink is ready. The
// block is not ready while it is working or emitting.
module md5_stream_hash (
    input  logic i_clk,
    input  logic i_rst_n,
    md5_stream_if.sink   s_in,
    md5_stream_if.source m_out
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BYTE = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_FOLD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_data;
    logic [2:0]  r_cnt;
    logic [1:0]  r_idx;
    logic        r_end;
    logic        r_pad_mark;
    logic        r_post;
    logic [63:0] r_len;
    logic [5:0]  r_pos;
    logic [31:0] r_chain [4];
    logic [31:0] r_mem [16];
    logic [31:0] r_msg;
    logic [31:0] sums [4];
    logic [5:0]  rnd;
    logic [5:0]  pos;
    logic [3:0]  g_next;
    logic [7:0]  pad_byte;
    md5_pkg::t_round_ctl ctl;
    md5_pkg::t_in_beat   in_b;

    assign in_b = s_in.payload;
    assign pos  = r_pos;

    always_comb begin
        if (r_pad_mark)
            pad_byte = md5_pkg::PAD_BYTE;
        else if (r_post && pos >= 6'd56)
            pad_byte = r_len[{pos[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    // message word for the round in flight, registered: fetched in the cycle before that round
    always_comb begin
        if (r_state == ST_RND)
            g_next = md5_pkg::round_g(rnd + 6'd1);
        else
            g_next = 4'd0;
    end

    always_ff @(posedge i_clk) begin
        r_msg <= r_mem[g_next];
        if (r_state == ST_BYTE && r_cnt != 3'd0)
            r_mem[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= r_data[7:0];
        else if (r_state == ST_PAD)
            r_mem[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= pad_byte;
    end

    assign ctl.start = (n_state == ST_RND) && (r_state != ST_RND);
    assign ctl.busy  = (r_state == ST_RND);
    assign ctl.done  = (r_state == ST_RND) && (rnd == 6'd63);

    md5_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_chain (r_chain),
        .i_msg   (r_msg),
        .o_round (rnd),
        .o_sum   (sums)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_in.valid) n_state = ST_BYTE;
            ST_BYTE: begin
                if (r_cnt == 3'd0)
                    n_state = r_end ? ST_PAD : ST_IDLE;
                else if (pos == 6'd63)
                    n_state = ST_RND;
            end
            ST_PAD:  if (pos == 6'd63) n_state = ST_RND;
            ST_RND:  if (ctl.done) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_cnt != 3'd0)
                    n_state = ST_BYTE;
                else if (r_end)
                    n_state = r_post ? ST_OUT : ST_PAD;
                else
                    n_state = ST_IDLE;
            end
            ST_OUT:  if (m_out.ready && r_idx == 2'd3) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= '0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_end      <= 1'b0;
            r_idx      <= '0;
            r_pad_mark <= 1'b0;
            r_post     <= 1'b0;
            r_chain[0] <= md5_pkg::IV_A;
            r_chain[1] <= md5_pkg::IV_B;
            r_chain[2] <= md5_pkg::IV_C;
            r_chain[3] <= md5_pkg::IV_D;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: if (s_in.valid) begin
                    r_data     <= in_b.data_bytes;
                    r_cnt      <= (in_b.byte_count > 3'd4) ? 3'd4 : in_b.byte_count;
                    r_end      <= in_b.end_of_message;
                    r_pad_mark <= 1'b1;
                    r_post     <= 1'b0;
                end
                ST_BYTE: if (r_cnt != 3'd0) begin
                    r_data <= r_data >> 8;
                    r_cnt  <= r_cnt - 3'd1;
                    r_len  <= r_len + 64'd8;
                    r_pos  <= r_pos + 6'd1;
                end
                ST_PAD: begin
                    r_pad_mark <= 1'b0;
                    r_pos      <= r_pos + 6'd1;
                    // the length goes into the block that reaches byte 55
                    if ((r_pad_mark && pos <= 6'd55) || pos == 6'd55)
                        r_post <= 1'b1;
                end
                ST_FOLD: for (int k = 0; k < 4; k++) r_chain[k] <= sums[k];
                ST_OUT: if (m_out.ready) begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_len      <= '0;
                        r_chain[0] <= md5_pkg::IV_A;
                        r_chain[1] <= md5_pkg::IV_B;
                        r_chain[2] <= md5_pkg::IV_C;
                        r_chain[3] <= md5_pkg::IV_D;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_in.ready    = (r_state == ST_IDLE);
    assign m_out.valid   = (r_state == ST_OUT);
    assign m_out.payload = '{digest_word: r_chain[r_idx], word_index: r_idx,
                             last_word: (r_idx == 2'd3)};
endmodule

/* src/md5_stream_hash_checker.sv */
`timescale 1ns / 1ps
module md5_stream_hash_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input md5_pkg::t_out_beat i_out_p
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("input ready while emitting");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_p))
        else $error("output beat changed under stall");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_p.last_word |=> i_out_valid &&
        i_out_p.word_index == $past(i_out_p.word_index) + 2'd1)
        else $error("digest words out of order");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_p.last_word == (i_out_p.word_index == 2'd3))
        else $error("last flag mismatch");
endmodule

bind md5_stream_hash md5_stream_hash_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_out_p(m_out.payload)
);
